>>> rtl/cppt_pkg.sv
// Shared types and constants for the convex polygon point test block.
`default_nettype none

package cppt_pkg;

    // Coordinate width of the vertex and query fields.
    localparam int COORD_W = 16;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
    } cmd_item_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
        logic vertices_dropped;
    } rsp_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    // Control of the vertex cell row.
    typedef struct packed {
        logic append;
        logic rotate;
    } cell_ctl_t;

    // One edge handed to the edge evaluator.
    typedef struct packed {
        logic    issue;
        vertex_t v0;
        vertex_t v1;
        vertex_t pt;
    } edge_req_t;

    // Status returned by the edge evaluator.
    typedef struct packed {
        logic busy;
        logic result_valid;
        logic reject;
    } edge_stat_t;

endpackage

`default_nettype wire

>>> rtl/cppt_cell.sv
// One vertex cell of the rotating polygon ring.
`default_nettype none

module cppt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire                  clk,
    input  cppt_pkg::cell_ctl_t  ctl,
    input  wire [CNT_W-1:0]      count,
    input  cppt_pkg::vertex_t    wr_vertex,
    input  cppt_pkg::vertex_t    head,
    input  cppt_pkg::vertex_t    nbr,
    output cppt_pkg::vertex_t    vertex
);
    import cppt_pkg::*;

    vertex_t vertex_reg;
    vertex_t vertex_next;

    always_comb
    begin
        vertex_next = vertex_reg;
        if (ctl.append && (count == CNT_W'(INDEX)))
        begin
            vertex_next = wr_vertex;
        end
        else if (ctl.rotate && (CNT_W'(INDEX) < count))
        begin
            // The last occupied cell closes the ring by taking the head vertex.
            vertex_next = (count == CNT_W'(INDEX + 1)) ? head : nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        vertex_reg <= vertex_next;
    end

    assign vertex = vertex_reg;

endmodule

`default_nettype wire

>>> rtl/cppt_edge.sv
// Three-stage pipeline that tests one polygon edge against the query point.
`default_nettype none

module cppt_edge #(
    parameter int CNT_W = 5,
    parameter int SUM_W = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  cppt_pkg::edge_req_t     req,
    input  wire signed [SUM_W-1:0]  sum_x,
    input  wire signed [SUM_W-1:0]  sum_y,
    input  wire [CNT_W-1:0]         count,
    output cppt_pkg::edge_stat_t    stat
);
    import cppt_pkg::*;

    localparam int D_W = COORD_W + 1;
    localparam int C_W = SUM_W + 1;
    localparam int P_W = D_W + C_W + 1;

    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [D_W-1:0]  ex_reg, ey_reg, dpx_reg, dpy_reg;
    logic signed [SUM_W-1:0] nx_reg, ny_reg;
    logic signed [P_W-1:0]  pa_reg, pb_reg, ca_reg, cb_reg;
    logic                   reject_reg;

    logic signed [SUM_W-1:0] cnt_s;
    logic signed [C_W-1:0]   dcx, dcy;
    logic signed [P_W-1:0]   dp, dc;
    logic                    dp_pos, dp_neg, dc_pos, dc_neg;
    logic                    reject_next;

    assign cnt_s = $signed(SUM_W'(count));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: edge vector, point offset and count-scaled start vertex.
    always_ff @(posedge clk)
    begin
        ex_reg  <= D_W'(req.v1.x) - D_W'(req.v0.x);
        ey_reg  <= D_W'(req.v1.y) - D_W'(req.v0.y);
        dpx_reg <= D_W'(req.pt.x) - D_W'(req.v0.x);
        dpy_reg <= D_W'(req.pt.y) - D_W'(req.v0.y);
        nx_reg  <= cnt_s * SUM_W'(req.v0.x);
        ny_reg  <= cnt_s * SUM_W'(req.v0.y);
    end

    // Stage two: the four cross-product terms.
    assign dcx = C_W'(sum_x) - C_W'(nx_reg);
    assign dcy = C_W'(sum_y) - C_W'(ny_reg);

    always_ff @(posedge clk)
    begin
        pa_reg <= P_W'(ey_reg) * P_W'(dpx_reg);
        pb_reg <= P_W'(ex_reg) * P_W'(dpy_reg);
        ca_reg <= P_W'(ey_reg) * P_W'(dcx);
        cb_reg <= P_W'(ex_reg) * P_W'(dcy);
    end

    // Stage three: the point fails the edge when it lies strictly on the
    // opposite side from the centroid.
    always_comb
    begin
        dp          = pa_reg - pb_reg;
        dc          = ca_reg - cb_reg;
        dp_neg      = dp[P_W-1];
        dc_neg      = dc[P_W-1];
        dp_pos      = !dp[P_W-1] && (dp != '0);
        dc_pos      = !dc[P_W-1] && (dc != '0);
        reject_next = (dp_pos && dc_neg) || (dp_neg && dc_pos);
    end

    always_ff @(posedge clk)
    begin
        reject_reg <= reject_next;
    end

    assign stat.busy         = v1_reg | v2_reg | v3_reg;
    assign stat.result_valid = v3_reg;
    assign stat.reject       = reject_reg;

endmodule

`default_nettype wire

>>> rtl/convex_polygon_point_test_top.sv
// Top level of the convex polygon point test: request decode, vertex ring and query sequencer.
`default_nettype none

// Clear and append transactions are accepted one per cycle while no query is running and
// produce no response. A query on n >= 3 stored vertices walks the ring, which rotates
// one edge per cycle into the three-stage edge pipeline, waits for the pipeline to drain,
// then raises its response once any earlier response has been taken; cmd_ready rises with
// it. With fewer than three vertices the query skips the walk. One command runs at a time.
// Reset empties the polygon and clears the overflow mark; vertex contents are not reset.
module convex_polygon_point_test_top #(
    parameter int MAX_VERTICES = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_ready,
    input  cppt_pkg::cmd_item_t   cmd,
    output logic                  rsp_valid,
    input  wire                   rsp_ready,
    output cppt_pkg::rsp_item_t   rsp
);
    import cppt_pkg::*;

    // The count must hold the capacity itself; the sums grow by the log of the capacity.
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W = COORD_W + $clog2(MAX_VERTICES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        step_reg, step_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic                    ovf_reg, ovf_next;
    logic                    reject_reg, reject_next;
    logic                    degen_reg, degen_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_reg, rsp_next;
    vertex_t                 pt_reg, pt_next;

    logic                    accept;
    cell_ctl_t               cell_ctl;
    vertex_t                 cmd_vertex;
    vertex_t                 ring [MAX_VERTICES];
    edge_req_t               edge_req;
    edge_stat_t              edge_stat;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign accept     = cmd_valid && cmd_ready;
    assign cmd_vertex = '{x: cmd.coord_x, y: cmd.coord_y};

    // The vertex ring. Cell zero always holds the start of the edge under test
    // and cell one its end; during a query the occupied cells rotate once per
    // cycle, and after n rotations the boundary order is restored.
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        vertex_t nbr_vertex;

        if (k == MAX_VERTICES - 1)
        begin : g_last
            assign nbr_vertex = ring[0];
        end
        else
        begin : g_mid
            assign nbr_vertex = ring[k + 1];
        end

        cppt_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .count     (count_reg),
            .wr_vertex (cmd_vertex),
            .head      (ring[0]),
            .nbr       (nbr_vertex),
            .vertex    (ring[k])
        );
    end

    assign edge_req.issue = (state_reg == ST_WALK);
    assign edge_req.v0    = ring[0];
    assign edge_req.v1    = ring[1];
    assign edge_req.pt    = pt_reg;

    cppt_edge #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (edge_req),
        .sum_x (sum_x_reg),
        .sum_y (sum_y_reg),
        .count (count_reg),
        .stat  (edge_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        ovf_next       = ovf_reg;
        reject_next    = reject_reg;
        degen_next     = degen_reg;
        pt_next        = pt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_ctl       = '0;

        // Any edge that sees the point on the far side rejects the query.
        if (edge_stat.result_valid && edge_stat.reject)
        begin
            reject_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            sum_x_next = '0;
                            sum_y_next = '0;
                            ovf_next   = 1'b0;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_VERTICES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                cell_ctl.append = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                sum_x_next      = sum_x_reg + SUM_W'(cmd.coord_x);
                                sum_y_next      = sum_y_reg + SUM_W'(cmd.coord_y);
                            end
                        end
                        REQ_QUERY:
                        begin
                            pt_next     = cmd_vertex;
                            reject_next = 1'b0;
                            step_next   = '0;
                            degen_next  = (count_reg < CNT_W'(3));
                            state_next  = (count_reg < CNT_W'(3)) ? ST_DONE : ST_WALK;
                        end
                        default:
                        begin
                            // The unused request code is taken and ignored.
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cell_ctl.rotate = 1'b1;
                step_next       = step_reg + CNT_W'(1);
                if (step_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!edge_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.inside_res       = !degen_reg && !reject_reg;
                    rsp_next.degenerate       = degen_reg;
                    rsp_next.vertices_dropped = ovf_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            ovf_reg       <= 1'b0;
            reject_reg    <= 1'b0;
            degen_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            ovf_reg       <= ovf_next;
            reject_reg    <= reject_next;
            degen_reg     <= degen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg  <= pt_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> tb/tb_convex_polygon_point_test_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the convex polygon point test block, with its own polygon predictor.
module tb_convex_polygon_point_test_top;
    import cppt_pkg::*;

    // The block is built with its default vertex capacity.
    localparam int POLY_CAP = 16;
    // The one request code that the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint COORD_MIN = -32768;
    localparam longint COORD_MAX = 32767;
    // About 1800 items are sent, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Settling time for the last response, with a margin beyond a query on a full polygon.
    localparam int SETTLE_CYCLES = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    convex_polygon_point_test_top #(
        .MAX_VERTICES(POLY_CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Polygon predictor. It keeps its own copy of the stored polygon and
    // works out the verdict for every query transaction at the moment the
    // block accepts it. All products stay well inside 64 bits: an edge
    // component needs 17 bits and a count-scaled centroid offset 21 bits.
    // ------------------------------------------------------------------
    longint    corner_x [POLY_CAP];
    longint    corner_y [POLY_CAP];
    int        corner_total   = 0;
    longint    corner_sum_x   = 0;
    longint    corner_sum_y   = 0;
    bit        append_dropped = 1'b0;
    rsp_item_t pending_verdicts [$];

    // Sign of p*q - r*s: which side of an edge line a point lies on.
    function automatic int cross_sign(longint p, longint q, longint r, longint s);
        longint d;
        d = p * q - r * s;
        if (d > 0)
            return 1;
        if (d < 0)
            return -1;
        return 0;
    endfunction

    // A point is inside when no edge puts it strictly on the opposite side from
    // the centroid. The centroid is kept scaled by the vertex count, so each
    // edge start is scaled the same way before the comparison.
    function automatic bit point_within_polygon(longint px, longint py);
        longint n;
        longint x0;
        longint y0;
        longint ex;
        longint ey;
        int     j;
        int     side_pt;
        int     side_mid;
        n = corner_total;
        for (int i = 0; i < corner_total; i++)
        begin
            j  = (i + 1 < corner_total) ? i + 1 : 0;
            x0 = corner_x[i];
            y0 = corner_y[i];
            ex = corner_x[j] - x0;
            ey = corner_y[j] - y0;
            side_pt  = cross_sign(ey, px - x0, ex, py - y0);
            side_mid = cross_sign(ey, corner_sum_x - n * x0, ex, corner_sum_y - n * y0);
            if (side_pt * side_mid < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void apply_to_polygon_model(cmd_item_t c);
        rsp_item_t verdict;
        longint    px;
        longint    py;
        px = $signed(c.coord_x);
        py = $signed(c.coord_y);
        case (c.req_type)
            REQ_CLEAR:
            begin
                corner_total   = 0;
                corner_sum_x   = 0;
                corner_sum_y   = 0;
                append_dropped = 1'b0;
            end
            REQ_APPEND:
            begin
                // A full polygon drops the vertex and remembers that it did.
                if (corner_total >= POLY_CAP)
                    append_dropped = 1'b1;
                else
                begin
                    corner_x[corner_total] = px;
                    corner_y[corner_total] = py;
                    corner_total++;
                    corner_sum_x += px;
                    corner_sum_y += py;
                end
            end
            REQ_QUERY:
            begin
                // Fewer than three vertices cannot enclose anything.
                verdict.degenerate       = (corner_total < 3);
                verdict.inside_res       = !verdict.degenerate && point_within_polygon(px, py);
                verdict.vertices_dropped = append_dropped;
                pending_verdicts.insert(pending_verdicts.size(), verdict);
            end
            default:
            begin
                // The unused code leaves the polygon untouched and answers nothing.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by the stimulus and the response checker.
    // ------------------------------------------------------------------
    int        error_count     = 0;
    int        items_sent      = 0;
    int        queries_sent    = 0;
    int        verdicts_seen   = 0;
    int        inside_seen     = 0;
    int        degenerate_seen = 0;
    int        dropped_seen    = 0;
    int        cycle_count     = 0;
    int        stall_left      = 0;
    bit        idling_on       = 1'b1;
    rsp_item_t want;
    string     bad_fields;

    // The stimulus keeps its own list of the vertices stored, used only to aim queries.
    longint shape_x [$];
    longint shape_y [$];

    task automatic report_mismatch(input string msg);
        error_count++;
        // Past the first hundred the mismatches are still counted but no longer printed.
        if (error_count <= 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Each response transaction is matched against the oldest verdict still outstanding.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("response %b arrived with no query outstanding", rsp));
            else
            begin
                want       = pending_verdicts.pop_front();
                bad_fields = "";
                if (rsp.inside_res !== want.inside_res)
                    bad_fields = {bad_fields, " inside_res"};
                if (rsp.degenerate !== want.degenerate)
                    bad_fields = {bad_fields, " degenerate"};
                if (rsp.vertices_dropped !== want.vertices_dropped)
                    bad_fields = {bad_fields, " vertices_dropped"};
                if (bad_fields != "")
                    report_mismatch($sformatf("response %0d wrong in%s: got %b, expected %b",
                                              verdicts_seen, bad_fields, rsp, want));
                verdicts_seen++;
                inside_seen     += want.inside_res;
                degenerate_seen += want.degenerate;
                dropped_seen    += want.vertices_dropped;
            end
        end
    end

    // Response back-pressure: random stalls while idling is enabled.
    always @(negedge clk)
    begin
        if (!idling_on)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
        else
            rsp_ready <= 1'b1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses outstanding",
                     cycle_count, pending_verdicts.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] sat16(longint v);
        longint c;
        c = v;
        if (c > COORD_MAX)
            c = COORD_MAX;
        if (c < COORD_MIN)
            c = COORD_MIN;
        return c[COORD_W-1:0];
    endfunction

    function automatic longint rand_coord();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic longint extreme_coord();
        case ($urandom_range(0, 2))
            0:       return COORD_MIN;
            1:       return 0;
            default: return COORD_MAX;
        endcase
    endfunction

    function automatic cmd_item_t make_cmd(logic [1:0] req, longint x, longint y);
        cmd_item_t c;
        c.req_type = req;
        c.coord_x  = sat16(x);
        c.coord_y  = sat16(y);
        return c;
    endfunction

    // Sends one command transaction, sometimes after an idle gap during which the payload
    // is scrambled, and updates the predictor on acceptance.
    task automatic send_cmd(input cmd_item_t item);
        int          gap;
        logic [63:0] junk;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap  = $urandom_range(1, 16);
            junk = {$urandom(), $urandom()};
            @(negedge clk);
            cmd_valid <= 1'b0;
            cmd       <= junk[$bits(cmd_item_t)-1:0];
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        apply_to_polygon_model(item);
        if (item.req_type != REQ_UNUSED)
            items_sent++;
        if (item.req_type == REQ_QUERY)
            queries_sent++;
    endtask

    // Holds the command side idle until every outstanding query has been answered.
    task automatic wait_for_responses();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Appends k vertices spread round an ellipse, so that the polygon is convex
    // apart from rounding and clamping at the coordinate limits. The winding is
    // chosen at random; a scrambled order gives a misordered polygon instead.
    task automatic build_polygon(input int k, input bit scramble);
        longint ax [24];
        longint ay [24];
        longint cx;
        longint cy;
        longint rx;
        longint ry;
        longint t;
        int     rmax;
        int     j;
        bit     reverse;
        real    base;
        real    step;
        real    ang;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rmax = 200;
            5, 6, 7:       rmax = 6000;
            default:       rmax = 40000;
        endcase
        rx = $urandom_range(1, rmax);
        ry = $urandom_range(1, rmax);
        if (rmax > 6000)
        begin
            cx = longint'($urandom_range(0, 4000)) - 2000;
            cy = longint'($urandom_range(0, 4000)) - 2000;
        end
        else
        begin
            cx = rand_coord();
            cy = rand_coord();
        end
        base = $urandom_range(0, 6283) / 1000.0;
        step = 6.283185307 / ((k > 0) ? k : 1);
        for (int i = 0; i < k; i++)
        begin
            ang   = base + step * (real'(i) + $urandom_range(0, 800) / 1000.0);
            ax[i] = cx + $rtoi(rx * $cos(ang));
            ay[i] = cy + $rtoi(ry * $sin(ang));
        end
        if (scramble)
        begin
            for (int i = k - 1; i > 0; i--)
            begin
                j     = $urandom_range(0, i);
                t     = ax[i];
                ax[i] = ax[j];
                ax[j] = t;
                t     = ay[i];
                ay[i] = ay[j];
                ay[j] = t;
            end
        end
        reverse = $urandom_range(0, 1);
        for (int i = 0; i < k; i++)
        begin
            j = reverse ? k - 1 - i : i;
            send_cmd(make_cmd(REQ_APPEND, ax[j], ay[j]));
            if (shape_x.size() < POLY_CAP)
            begin
                shape_x.insert(shape_x.size(), longint'(sat16(ax[j])));
                shape_y.insert(shape_y.size(), longint'(sat16(ay[j])));
            end
        end
    endtask

    // Aims a query at the current polygon: its vertices, points on its edges and near its
    // vertices, its centroid, its bounding box, or anywhere at all.
    function automatic cmd_item_t pick_query();
        int     n;
        int     i;
        int     j;
        int     mode;
        longint qx;
        longint qy;
        longint lo_x;
        longint hi_x;
        longint lo_y;
        longint hi_y;
        longint span_x;
        longint span_y;
        longint frac;
        n    = shape_x.size();
        mode = (n == 0) ? 8 : $urandom_range(0, 9);
        i    = (n == 0) ? 0 : $urandom_range(0, n - 1);
        j    = (i + 1 < n) ? i + 1 : 0;
        case (mode)
            0, 1:
            begin
                qx = shape_x[i];
                qy = shape_y[i];
            end
            2:
            begin
                qx = (shape_x[i] + shape_x[j]) / 2;
                qy = (shape_y[i] + shape_y[j]) / 2;
            end
            3:
            begin
                qx = shape_x[i] + longint'($urandom_range(0, 4)) - 2;
                qy = shape_y[i] + longint'($urandom_range(0, 4)) - 2;
            end
            4:
            begin
                qx = 0;
                qy = 0;
                for (int m = 0; m < n; m++)
                begin
                    qx += shape_x[m];
                    qy += shape_y[m];
                end
                qx = qx / n;
                qy = qy / n;
            end
            5, 6:
            begin
                lo_x = shape_x[0];
                hi_x = shape_x[0];
                lo_y = shape_y[0];
                hi_y = shape_y[0];
                for (int m = 1; m < n; m++)
                begin
                    if (shape_x[m] < lo_x) lo_x = shape_x[m];
                    if (shape_x[m] > hi_x) hi_x = shape_x[m];
                    if (shape_y[m] < lo_y) lo_y = shape_y[m];
                    if (shape_y[m] > hi_y) hi_y = shape_y[m];
                end
                span_x = (hi_x - lo_x) / 8 + 2;
                span_y = (hi_y - lo_y) / 8 + 2;
                qx = lo_x - span_x + longint'($urandom_range(0, hi_x - lo_x + 2 * span_x));
                qy = lo_y - span_y + longint'($urandom_range(0, hi_y - lo_y + 2 * span_y));
            end
            7:
            begin
                frac = $urandom_range(0, 64);
                qx   = shape_x[i] + (shape_x[j] - shape_x[i]) * frac / 64;
                qy   = shape_y[i] + (shape_y[j] - shape_y[i]) * frac / 64;
            end
            8:
            begin
                qx = rand_coord();
                qy = rand_coord();
            end
            default:
            begin
                qx = extreme_coord();
                qy = extreme_coord();
            end
        endcase
        return make_cmd(REQ_QUERY, qx, qy);
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked cases: empty and two-vertex polygons, coordinates at both
    // limits, points on vertices and edges, a repeated vertex, a polygon that
    // has collapsed to a point or a line, the unused request code, and clear.
    task automatic test_directed_cases();
        send_cmd(make_cmd(REQ_QUERY, 0, 0));
        send_cmd(make_cmd(REQ_APPEND, COORD_MIN, COORD_MIN));
        send_cmd(make_cmd(REQ_APPEND, COORD_MAX, COORD_MIN));
        send_cmd(make_cmd(REQ_QUERY, COORD_MAX, COORD_MAX));
        send_cmd(make_cmd(REQ_APPEND, COORD_MAX, COORD_MAX));
        send_cmd(make_cmd(REQ_QUERY, 0, 0));
        send_cmd(make_cmd(REQ_QUERY, COORD_MIN, COORD_MAX));
        send_cmd(make_cmd(REQ_UNUSED, rand_coord(), rand_coord()));
        send_cmd(make_cmd(REQ_APPEND, COORD_MIN, COORD_MAX));
        send_cmd(make_cmd(REQ_QUERY, COORD_MIN, COORD_MAX));
        send_cmd(make_cmd(REQ_QUERY, COORD_MAX, 0));
        send_cmd(make_cmd(REQ_QUERY, -1, -1));
        // Repeating the last vertex gives a zero-length edge.
        send_cmd(make_cmd(REQ_APPEND, COORD_MIN, COORD_MAX));
        send_cmd(make_cmd(REQ_QUERY, 100, -200));
        // Three copies of one point: every edge has zero length.
        send_cmd(make_cmd(REQ_CLEAR, COORD_MAX, COORD_MIN));
        repeat (3) send_cmd(make_cmd(REQ_APPEND, 5, 5));
        send_cmd(make_cmd(REQ_QUERY, COORD_MIN, COORD_MAX));
        // Three points on one line: the centroid lies on every edge line.
        send_cmd(make_cmd(REQ_CLEAR, 0, 0));
        send_cmd(make_cmd(REQ_APPEND, 0, 0));
        send_cmd(make_cmd(REQ_APPEND, 100, 0));
        send_cmd(make_cmd(REQ_APPEND, 200, 0));
        send_cmd(make_cmd(REQ_QUERY, 50, 7));
        send_cmd(make_cmd(REQ_CLEAR, 0, 0));
        send_cmd(make_cmd(REQ_QUERY, 0, 0));
        shape_x.delete();
        shape_y.delete();
    endtask

    // Fills the polygon exactly, then pushes appends past capacity, and checks
    // that the overflow mark appears, persists and is wiped by clear.
    task automatic test_capacity_overflow();
        send_cmd(make_cmd(REQ_CLEAR, 0, 0));
        shape_x.delete();
        shape_y.delete();
        build_polygon(POLY_CAP, 1'b0);
        repeat (3) send_cmd(pick_query());
        send_cmd(make_cmd(REQ_APPEND, rand_coord(), rand_coord()));
        repeat (3) send_cmd(pick_query());
        send_cmd(make_cmd(REQ_APPEND, COORD_MAX, COORD_MAX));
        send_cmd(pick_query());
        send_cmd(make_cmd(REQ_CLEAR, 0, 0));
        send_cmd(make_cmd(REQ_QUERY, 0, 0));
        shape_x.delete();
        shape_y.delete();
    endtask

    // Random polygons, each built after a clear and then queried several times.
    // Most are convex in either winding; some are too small, overfull or scrambled.
    task automatic test_random_polygons(input int target, input bit allow_idle);
        int seq;
        int k;
        bit scramble;
        seq = 0;
        while (items_sent < target)
        begin
            seq++;
            // Idling comes and goes per polygon, leaving stretches without it.
            idling_on = allow_idle && ($urandom_range(0, 3) != 0);
            if (seq % 15 == 0)
                wait_for_responses();
            send_cmd(make_cmd(REQ_CLEAR, rand_coord(), rand_coord()));
            shape_x.delete();
            shape_y.delete();
            scramble = 1'b0;
            case ($urandom_range(0, 19))
                0:       k = $urandom_range(0, 2);
                1:       k = $urandom_range(POLY_CAP + 1, POLY_CAP + 4);
                2:
                begin
                    k        = $urandom_range(4, 10);
                    scramble = 1'b1;
                end
                default: k = $urandom_range(3, POLY_CAP);
            endcase
            build_polygon(k, scramble);
            repeat ($urandom_range(3, 12)) send_cmd(pick_query());
        end
    endtask

    // Unstructured traffic: every request code, unused one included, with
    // arbitrary coordinates, so polygons grow shapeless and often overflow.
    task automatic test_noise(input int count);
        int        pick;
        cmd_item_t c;
        idling_on = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                c = make_cmd(REQ_CLEAR, rand_coord(), rand_coord());
            else if (pick < 8)
                c = make_cmd(REQ_APPEND, rand_coord(), rand_coord());
            else if (pick < 16)
                c = make_cmd(REQ_QUERY, rand_coord(), rand_coord());
            else
                c = make_cmd(REQ_UNUSED, rand_coord(), rand_coord());
            send_cmd(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence. Reset is held at the start and never again.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_capacity_overflow();
        test_random_polygons(1200, 1'b1);
        test_noise(200);
        // The closing stretch runs flat out with no idling on either channel.
        test_random_polygons(1800, 1'b0);

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d transactions (%0d queries) over random convex, misordered,",
                 items_sent, queries_sent);
        $display("degenerate and overfull polygons; %0d responses: %0d inside, %0d degenerate, %s",
                 verdicts_seen, inside_seen, degenerate_seen,
                 $sformatf("%0d dropped", dropped_seen));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
